[rtl/core/tcw_pkg.sv]
// shared constants, codes and controller/datapath signal groups for the text console
package tcw_pkg;

  // default screen geometry
  localparam int SCREEN_ROWS_DEF    = 25;
  localparam int SCREEN_COLUMNS_DEF = 80;

  // payload field widths
  localparam int REQ_W      = 2;
  localparam int CHAR_W     = 8;
  localparam int ADDR_W     = 11;
  localparam int POS_W      = 11;
  localparam int VALUE_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam int ATTR_W     = 8;

  // request types
  localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

  // character codes
  localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CODE_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CODE_SPACE     = 8'd32;
  localparam logic [CHAR_W-1:0] CODE_NULL      = 8'd0;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FORE_COLOUR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BACK_COLOUR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAB_WIDTH   = 2'd2;

  // configuration reset values
  localparam logic [CFG_DATA_W-1:0] FORE_COLOUR_RESET = 4'd7;
  localparam logic [CFG_DATA_W-1:0] BACK_COLOUR_RESET = 4'd0;
  localparam logic [CFG_DATA_W-1:0] TAB_WIDTH_RESET   = 4'd4;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic put;
    logic put_space;
    logic backspace;
    logic newline;
    logic clear;
    logic sweep;
    logic tab_dec;
    logic read;
    logic result;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic             is_backspace;
    logic             is_newline;
    logic             is_tab;
    logic             put_scrolls;
    logic             at_bottom;
    logic             tab_zero;
    logic             sweep_last;
  } status_t;

endpackage

[rtl/core/tcw_if.sv]
// handshake channels of the text console: request, response and configuration
interface tcw_req_if import tcw_pkg::*;;
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [CHAR_W-1:0] char_code;
  logic [ADDR_W-1:0] cell_address;

  modport source (output valid, output req_type, output char_code, output cell_address,
                  input ready);
  modport sink (input valid, input req_type, input char_code, input cell_address,
                output ready);
endinterface

interface tcw_rsp_if import tcw_pkg::*;;
  logic               valid;
  logic               ready;
  logic [POS_W-1:0]   cursor_position;
  logic [VALUE_W-1:0] cell_value;

  modport source (output valid, output cursor_position, output cell_value, input ready);
  modport sink (input valid, input cursor_position, input cell_value, output ready);
endinterface

interface tcw_cfg_if import tcw_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/core/tcw_ctrl.sv]
// sequencing state machine of the text console
module tcw_ctrl import tcw_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  status_t status,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output cmd_t    cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_TAB   = 3'd2;
  localparam logic [2:0] S_SWEEP = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       init;

  assign in_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (status.req_type)
          REQ_PUT: begin
            priority if (status.is_backspace) begin
              cmd.backspace = 1'b1;
              state_next    = S_DONE;
            end else if (status.is_newline) begin
              cmd.newline = 1'b1;
              state_next  = status.at_bottom ? S_SWEEP : S_DONE;
            end else if (status.is_tab) begin
              state_next = S_TAB;
            end else begin
              cmd.put    = 1'b1;
              state_next = status.put_scrolls ? S_SWEEP : S_DONE;
            end
          end
          REQ_CLEAR: begin
            cmd.clear  = 1'b1;
            state_next = S_SWEEP;
          end
          REQ_READ: begin
            cmd.read   = 1'b1;
            state_next = S_DONE;
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_TAB: begin
        if (status.tab_zero) begin
          state_next = S_DONE;
        end else begin
          cmd.put       = 1'b1;
          cmd.put_space = 1'b1;
          cmd.tab_dec   = 1'b1;
          state_next    = status.put_scrolls ? S_SWEEP : S_TAB;
        end
      end
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (status.sweep_last) begin
          priority if (init) begin
            state_next = S_IDLE;
          end else if (status.tab_zero) begin
            state_next = S_DONE;
          end else begin
            state_next = S_TAB;
          end
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.result = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state, power-up sweep flag and response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_SWEEP;
      init      <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_SWEEP && status.sweep_last) begin
        init <= 1'b0;
      end
      if (cmd.result) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/core/tcw_datapath.sv]
// cursor, scroll pointer, configuration, screen store and response registers
module tcw_datapath import tcw_pkg::*; #(
  parameter int SCREEN_ROWS    = SCREEN_ROWS_DEF,
  parameter int SCREEN_COLUMNS = SCREEN_COLUMNS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output status_t            status,
  input  logic [REQ_W-1:0]   req_type,
  input  logic [CHAR_W-1:0]  char_code,
  input  logic [ADDR_W-1:0]  cell_address,
  tcw_cfg_if.sink            cfg,
  output logic [POS_W-1:0]   cursor_position,
  output logic [VALUE_W-1:0] cell_value
);

  localparam int CELL_COUNT = SCREEN_ROWS * SCREEN_COLUMNS;
  localparam int CELL_W     = $clog2(CELL_COUNT);
  localparam int ROW_W      = $clog2(SCREEN_ROWS);
  localparam int COL_W      = $clog2(SCREEN_COLUMNS);
  localparam int SUM_W      = ((CELL_W > ADDR_W) ? CELL_W : ADDR_W) + 1;

  localparam logic [CELL_W-1:0] LAST_ROW_BASE = CELL_W'((SCREEN_ROWS - 1) * SCREEN_COLUMNS);
  localparam logic [CELL_W-1:0] ROW_SPAN      = CELL_W'(SCREEN_COLUMNS);
  localparam logic [CELL_W-1:0] LAST_CELL     = CELL_W'(CELL_COUNT - 1);
  localparam logic [CELL_W:0]   CELL_COUNT_X  = (CELL_W + 1)'(CELL_COUNT);
  localparam logic [SUM_W-1:0]  CELL_COUNT_S  = SUM_W'(CELL_COUNT);
  localparam logic [ROW_W-1:0]  LAST_ROW      = ROW_W'(SCREEN_ROWS - 1);
  localparam logic [COL_W-1:0]  LAST_COL      = COL_W'(SCREEN_COLUMNS - 1);

  // screen store, physical rows form a ring starting at top_base
  logic [VALUE_W-1:0] screen [CELL_COUNT];

  logic [REQ_W-1:0]      req_q;
  logic [CHAR_W-1:0]     char_q;
  logic [ADDR_W-1:0]     addr_q;
  logic [ROW_W-1:0]      cursor_row;
  logic [COL_W-1:0]      cursor_column;
  logic [CELL_W-1:0]     cursor_pos;
  logic [CELL_W-1:0]     top_base;
  logic [CELL_W-1:0]     sweep_addr;
  logic [CELL_W-1:0]     sweep_end;
  logic                  fill_zero;
  logic [CFG_DATA_W-1:0] fore_colour;
  logic [CFG_DATA_W-1:0] back_colour;
  logic [CFG_DATA_W-1:0] tab_width;
  logic [CFG_DATA_W-1:0] tab_count;
  logic [VALUE_W-1:0]    rd_data;

  logic [ATTR_W-1:0]  attr;
  logic [CELL_W:0]    cur_sum;
  logic [CELL_W-1:0]  cur_phys;
  logic [SUM_W-1:0]   rd_sum;
  logic               rd_ok;
  logic [CELL_W-1:0]  rd_addr;
  logic               col_nz;
  logic               scroll;
  logic               mem_we;
  logic [CELL_W-1:0]  mem_wa;
  logic [VALUE_W-1:0] mem_wd;

  assign cfg.ready = 1'b1;
  assign attr      = {back_colour, fore_colour};
  assign col_nz    = (cursor_column != '0);

  // physical address of the cursor cell
  always_comb begin
    cur_sum = {1'b0, cursor_pos} + {1'b0, top_base};
    if (cur_sum >= CELL_COUNT_X) begin
      cur_phys = CELL_W'(cur_sum - CELL_COUNT_X);
    end else begin
      cur_phys = CELL_W'(cur_sum);
    end
  end

  // physical address of a read
  always_comb begin
    rd_ok  = (SUM_W'(addr_q) < CELL_COUNT_S);
    rd_sum = SUM_W'(addr_q) + SUM_W'(top_base);
    if (!rd_ok) begin
      rd_addr = '0;
    end else if (rd_sum >= CELL_COUNT_S) begin
      rd_addr = CELL_W'(rd_sum - CELL_COUNT_S);
    end else begin
      rd_addr = CELL_W'(rd_sum);
    end
  end

  assign scroll = (cmd.put && status.put_scrolls) || (cmd.newline && status.at_bottom);

  // status to the controller
  always_comb begin
    status.req_type     = req_q;
    status.is_backspace = (char_q == CODE_BACKSPACE);
    status.is_newline   = (char_q == CODE_NEWLINE);
    status.is_tab       = (char_q == CODE_TAB);
    status.at_bottom    = (cursor_row == LAST_ROW);
    status.put_scrolls  = (cursor_column == LAST_COL) && (cursor_row == LAST_ROW);
    status.tab_zero     = (tab_count == '0);
    status.sweep_last   = (sweep_addr == sweep_end);
  end

  // store write port
  always_comb begin
    mem_we = 1'b0;
    mem_wa = cur_phys;
    mem_wd = {attr, char_q};
    priority if (cmd.sweep) begin
      mem_we = 1'b1;
      mem_wa = sweep_addr;
      mem_wd = fill_zero ? '0 : {attr, CODE_NULL};
    end else if (cmd.put) begin
      mem_we = 1'b1;
      mem_wd = {attr, cmd.put_space ? CODE_SPACE : char_q};
    end else if (cmd.backspace && col_nz) begin
      mem_we = 1'b1;
      mem_wa = cur_phys - CELL_W'(1);
      mem_wd = {attr, CODE_SPACE};
    end else begin
      mem_we = 1'b0;
    end
  end

  // screen store with registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      screen[mem_wa] <= mem_wd;
    end
    if (cmd.read) begin
      rd_data <= screen[rd_addr];
    end
  end

  // request fields
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q  <= req_type;
      char_q <= char_code;
      addr_q <= cell_address;
    end
  end

  // cursor, ring pointer, sweep range, configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_row    <= '0;
      cursor_column <= '0;
      cursor_pos    <= '0;
      top_base      <= '0;
      sweep_addr    <= '0;
      sweep_end     <= LAST_CELL;
      fill_zero     <= 1'b1;
      fore_colour   <= FORE_COLOUR_RESET;
      back_colour   <= BACK_COLOUR_RESET;
      tab_width     <= TAB_WIDTH_RESET;
      tab_count     <= '0;
    end else begin
      // configuration beat
      if (cfg.valid) begin
        unique case (cfg.index)
          CFG_FORE_COLOUR: fore_colour <= cfg.data;
          CFG_BACK_COLOUR: back_colour <= cfg.data;
          CFG_TAB_WIDTH:   tab_width   <= cfg.data;
          default:         ;
        endcase
      end

      // tab repeat count
      if (cmd.load) begin
        tab_count <= (req_type == REQ_PUT && char_code == CODE_TAB) ? tab_width : '0;
      end else if (cmd.tab_dec) begin
        tab_count <= tab_count - CFG_DATA_W'(1);
      end

      // clear: home cursor, reset ring, sweep whole store
      if (cmd.clear) begin
        cursor_row    <= '0;
        cursor_column <= '0;
        cursor_pos    <= '0;
        top_base      <= '0;
        sweep_addr    <= '0;
        sweep_end     <= LAST_CELL;
        fill_zero     <= 1'b0;
      end

      // advance after a cell write
      if (cmd.put) begin
        if (cursor_column == LAST_COL) begin
          cursor_column <= '0;
          if (cursor_row == LAST_ROW) begin
            cursor_pos <= LAST_ROW_BASE;
          end else begin
            cursor_row <= cursor_row + ROW_W'(1);
            cursor_pos <= cursor_pos + CELL_W'(1);
          end
        end else begin
          cursor_column <= cursor_column + COL_W'(1);
          cursor_pos    <= cursor_pos + CELL_W'(1);
        end
      end

      // step back within the line
      if (cmd.backspace && col_nz) begin
        cursor_column <= cursor_column - COL_W'(1);
        cursor_pos    <= cursor_pos - CELL_W'(1);
      end

      // start of next line
      if (cmd.newline) begin
        cursor_column <= '0;
        if (cursor_row == LAST_ROW) begin
          cursor_pos <= LAST_ROW_BASE;
        end else begin
          cursor_row <= cursor_row + ROW_W'(1);
          cursor_pos <= cursor_pos - CELL_W'(cursor_column) + ROW_SPAN;
        end
      end

      // scroll: old top row becomes the new bottom row and is blanked
      if (scroll) begin
        top_base   <= (top_base == LAST_ROW_BASE) ? '0 : top_base + ROW_SPAN;
        sweep_addr <= top_base;
        sweep_end  <= top_base + ROW_SPAN - CELL_W'(1);
        fill_zero  <= 1'b0;
      end

      if (cmd.sweep) begin
        sweep_addr <= sweep_addr + CELL_W'(1);
      end
    end
  end

  // response payload
  always_ff @(posedge clk) begin
    if (cmd.result) begin
      cursor_position <= POS_W'(cursor_pos);
      cell_value      <= (req_q == REQ_READ && rd_ok) ? rd_data : '0;
    end
  end

endmodule

[rtl/core/text_console_writer_top.sv]
// Text console top level: request beat in, one response beat out per request.
// A tab writes tab_width spaces, each scroll blanks one row of SCREEN_COLUMNS cells, and
// clear blanks all SCREEN_ROWS*SCREEN_COLUMNS cells before its response is given.
// One request in work at a time; a new request is taken while the previous response
// waits. Reset: cursor, scroll pointer and colours to reset values, then a clearing
// pass over the whole store, during which no request is taken.
module text_console_writer_top import tcw_pkg::*; #(
  parameter int SCREEN_ROWS    = SCREEN_ROWS_DEF,
  parameter int SCREEN_COLUMNS = SCREEN_COLUMNS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  tcw_req_if.sink    req,
  tcw_rsp_if.source  rsp,
  tcw_cfg_if.sink    cfg
);

  cmd_t    cmd;
  status_t status;

  // sequencer
  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .status    (status),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  // cursor, store and response payload
  tcw_datapath #(
    .SCREEN_ROWS    (SCREEN_ROWS),
    .SCREEN_COLUMNS (SCREEN_COLUMNS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .req_type        (req.req_type),
    .char_code       (req.char_code),
    .cell_address    (req.cell_address),
    .cfg             (cfg),
    .cursor_position (rsp.cursor_position),
    .cell_value      (rsp.cell_value)
  );

endmodule
